[design/nmea_pkg.sv]
// Shared types, constants and helper functions for the NMEA sentence parser.
// No dependencies; every module of the parser imports this package.
package nmea_pkg;

  localparam int unsigned BUFFER_SIZE_DEF        = 128;
  localparam int unsigned MINUTE_FRAC_DIGITS_DEF = 5;

  // Operation carried from the byte parser down the conversion pipeline.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_CLEAR,
    OP_FINISH,
    OP_COMMIT
  } evt_op_t;

  typedef enum logic [1:0] {
    KIND_GSA,
    KIND_GNS,
    KIND_VTG,
    KIND_UNKNOWN
  } kind_t;

  localparam logic [7:0]  NAV_MODE_3D    = 8'd3;
  localparam logic [7:0]  NAV_MODE_RESET = 8'd1;
  localparam logic [15:0] PDOP_RESET     = 16'd9999;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SOUTH  = 8'h53;
  localparam logic [7:0] CH_WEST   = 8'h57;

  localparam logic [4:0] FIELD_LAST = 5'd31;
  localparam logic [2:0] FRAC_MAX   = 3'd7;

  function automatic logic [23:0] pow10(input int k);
    logic [23:0] v;
    case (k)
      0:       v = 24'd1;
      1:       v = 24'd10;
      2:       v = 24'd100;
      3:       v = 24'd1000;
      4:       v = 24'd10000;
      5:       v = 24'd100000;
      6:       v = 24'd1000000;
      7:       v = 24'd10000000;
      default: v = 24'd1;
    endcase
    return v;
  endfunction

  // Snapshot of one finished field (or a control event) from the byte parser.
  typedef struct packed {
    evt_op_t     op;
    kind_t       kind;
    logic [4:0]  field;
    logic        neg;
    logic        hem_s;
    logic        hem_w;
    logic [31:0] int_val;
    logic [25:0] deg;
    logic [6:0]  rem;
    logic [3:0]  f1;
    logic [6:0]  f2;
    logic [9:0]  f3;
    logic [23:0] fm;
  } fld_evt_t;

  // Converted values of one field, ready to be written into the shadow set.
  typedef struct packed {
    evt_op_t            op;
    kind_t              kind;
    logic [4:0]         field;
    logic               hem_s;
    logic               hem_w;
    logic [7:0]         small_v;
    logic [15:0]        pdop_v;
    logic signed [20:0] alt_v;
    logic [23:0]        spd_v;
    logic signed [31:0] coord_v;
  } shd_evt_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         mode;
    logic [15:0]        pdop;
    logic signed [31:0] lat;
    logic signed [31:0] lon;
    logic [7:0]         sats;
    logic signed [20:0] alt;
    logic [23:0]        spd;
  } res_t;

endpackage

[design/nmea_sentence_parser.sv]
// Top level of the NMEA-0183 GSA/GNS/VTG sentence parser.
// Depends on nmea_pkg, nmea_front, nmea_conv and nmea_commit.
//
//   Channel   Direction  Width        Contents
//   in_*      slave      8 (tdata)    one received character per beat
//   out_*     master     144 + 2      committed navigation values, sentence kind
//
// One character is accepted per clock cycle while the pipeline is not held. A
// character runs through the byte parser register, three conversion stages and
// the commit stage before the result beat of its sentence appears.
// Reset (rst_n low, synchronous) clears the parser, the shadow values and the
// committed state (mode 1, PDOP 99.99). When a result beat waits and out_tready
// is low, the whole pipeline holds and in_tready drops in the same cycle.
module nmea_sentence_parser import nmea_pkg::*; #(
  parameter int unsigned BUFFER_SIZE        = BUFFER_SIZE_DEF,
  parameter int unsigned MINUTE_FRAC_DIGITS = MINUTE_FRAC_DIGITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] rx_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  // [7:0] nav_mode, [23:8] pdop_centi, [55:24] lat_deg_e7, [87:56] lon_deg_e7,
  // [95:88] num_sats, [116:96] alt_decim, [140:117] speed_kph_milli, rest zero
  output logic [143:0] out_tdata,
  output logic [1:0]   out_tuser   // [1:0] sentence_kind
);

  logic     adv, accept;
  fld_evt_t fld_evt;
  shd_evt_t shd_evt;
  res_t     res;

  // The pipeline moves whenever the result register is empty or being taken.
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;
  assign accept    = in_tvalid && adv;

  nmea_front #(
    .BUFFER_SIZE        (BUFFER_SIZE),
    .MINUTE_FRAC_DIGITS (MINUTE_FRAC_DIGITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .accept  (accept),
    .in_byte (in_tdata),
    .evt_o   (fld_evt)
  );

  nmea_conv #(
    .MINUTE_FRAC_DIGITS (MINUTE_FRAC_DIGITS)
  ) u_conv (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .evt_i (fld_evt),
    .evt_o (shd_evt)
  );

  nmea_commit u_commit (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .evt_i       (shd_evt),
    .out_valid_o (out_tvalid),
    .out_res_o   (res)
  );

  assign out_tuser = res.kind;
  assign out_tdata = {3'b000, res.spd, res.alt, res.sats, res.lon, res.lat,
                      res.pdop, res.mode};

  // Only recognized sentence kinds ever produce a result.
  a_kind_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != KIND_UNKNOWN)
    else $error("result beat with unknown sentence kind");

  // Position and speed are only committed under a 3D fix.
  a_fix_gate: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != KIND_GSA) |-> out_tdata[7:0] == NAV_MODE_3D)
    else $error("GNS or VTG result without 3D fix");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat right after reset");

endmodule

[design/nmea_front.sv]
// Byte-level sentence parser: framing, checksum, type and digit accumulation.
// Depends on nmea_pkg; emits one registered event per accepted byte.
module nmea_front import nmea_pkg::*; #(
  parameter int unsigned BUFFER_SIZE        = BUFFER_SIZE_DEF,
  parameter int unsigned MINUTE_FRAC_DIGITS = MINUTE_FRAC_DIGITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     adv,
  input  logic     accept,
  input  logic [7:0] in_byte,
  output fld_evt_t evt_o
);

  localparam int unsigned CW = $clog2(BUFFER_SIZE);
  localparam logic [CW-1:0] BODY_MAX = CW'(BUFFER_SIZE - 1);

  typedef enum logic [1:0] {PH_IDLE, PH_BODY, PH_HEX1, PH_HEX2} phase_t;

  phase_t      phase_r, phase_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [7:0]  chk_r, chk_nxt;
  kind_t       kind_r, kind_nxt;
  logic [7:0]  addr3_r, addr3_nxt, addr4_r, addr4_nxt;
  logic [4:0]  field_r, field_nxt;
  logic [31:0] int_r, int_nxt;
  logic [25:0] q_r, q_nxt;
  logic [6:0]  rem_r, rem_nxt;
  logic [3:0]  f1_r, f1_nxt;
  logic [6:0]  f2_r, f2_nxt;
  logic [9:0]  f3_r, f3_nxt;
  logic [23:0] fm_r, fm_nxt;
  logic [2:0]  fd_r, fd_nxt;
  logic        neg_r, neg_nxt, infrac_r, infrac_nxt, started_r, started_nxt;
  logic [7:0]  first_r, first_nxt;
  fld_evt_t    evt_r, evt_nxt;

  logic [7:0]  hexv;
  logic [3:0]  d;
  logic        is_digit, do_clear;
  logic [35:0] t36;
  logic [9:0]  v10;
  logic [3:0]  hi;

  always_comb begin
    phase_nxt = phase_r;   count_nxt = count_r;   xor_nxt = xor_r;
    chk_nxt = chk_r;       kind_nxt = kind_r;     addr3_nxt = addr3_r;
    addr4_nxt = addr4_r;   field_nxt = field_r;   int_nxt = int_r;
    q_nxt = q_r;           rem_nxt = rem_r;       f1_nxt = f1_r;
    f2_nxt = f2_r;         f3_nxt = f3_r;         fm_nxt = fm_r;
    fd_nxt = fd_r;         neg_nxt = neg_r;       infrac_nxt = infrac_r;
    started_nxt = started_r; first_nxt = first_r;
    do_clear = 1'b0;

    evt_nxt = '0;
    evt_nxt.op      = OP_NONE;
    evt_nxt.kind    = kind_r;
    evt_nxt.field   = field_r;
    evt_nxt.neg     = neg_r;
    evt_nxt.hem_s   = (first_r == CH_SOUTH);
    evt_nxt.hem_w   = (first_r == CH_WEST);
    evt_nxt.int_val = int_r;
    evt_nxt.deg     = q_r;
    evt_nxt.rem     = rem_r;
    evt_nxt.f1      = f1_r;
    evt_nxt.f2      = f2_r;
    evt_nxt.f3      = f3_r;
    evt_nxt.fm      = fm_r;

    hexv     = (in_byte < 8'd58) ? in_byte - 8'd48 : in_byte - 8'd55;
    d        = in_byte[3:0];
    is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    t36      = {4'b0, int_r} * 36'd10 + 36'(d);
    v10      = 10'(rem_r) * 10'd10 + 10'(d);
    hi       = '0;
    for (int k = 1; k < 10; k++) begin
      if (v10 >= 10'(k * 100)) hi = hi + 4'd1;
    end

    if (accept) begin
      if (in_byte == CH_DOLLAR) begin
        phase_nxt = PH_BODY;
        count_nxt = '0;
        xor_nxt   = '0;
        kind_nxt  = KIND_UNKNOWN;
        field_nxt = '0;
        addr3_nxt = '0;
        addr4_nxt = '0;
        do_clear  = 1'b1;
        evt_nxt.op = OP_CLEAR;
      end else if (in_byte == CH_STAR) begin
        if (phase_r == PH_BODY) begin
          if (count_r >= CW'(7)) begin
            evt_nxt.op = OP_FINISH;
            if (field_r != FIELD_LAST) field_nxt = field_r + 5'd1;
            do_clear = 1'b1;
          end
          phase_nxt = PH_HEX1;
        end
      end else begin
        unique case (phase_r)
          PH_BODY: begin
            if (count_r >= BODY_MAX) begin
              phase_nxt = PH_IDLE;
            end else begin
              xor_nxt   = xor_r ^ in_byte;
              count_nxt = count_r + CW'(1);
              if (count_nxt == CW'(3)) begin
                addr3_nxt = in_byte;
              end else if (count_nxt == CW'(4)) begin
                addr4_nxt = in_byte;
              end else if (count_nxt == CW'(5)) begin
                if (addr3_r == 8'h47 && addr4_r == 8'h53 && in_byte == 8'h41)
                  kind_nxt = KIND_GSA;
                else if (addr3_r == 8'h47 && addr4_r == 8'h4E && in_byte == 8'h53)
                  kind_nxt = KIND_GNS;
                else if (addr3_r == 8'h56 && addr4_r == 8'h54 && in_byte == 8'h47)
                  kind_nxt = KIND_VTG;
                else
                  kind_nxt = KIND_UNKNOWN;
              end else if (count_nxt >= CW'(7)) begin
                if (in_byte == CH_COMMA) begin
                  evt_nxt.op = OP_FINISH;
                  if (field_r != FIELD_LAST) field_nxt = field_r + 5'd1;
                  do_clear = 1'b1;
                end else begin
                  if (!started_r) begin
                    first_nxt   = in_byte;
                    started_nxt = 1'b1;
                  end
                  if (!started_r && in_byte == CH_MINUS) begin
                    neg_nxt = 1'b1;
                  end else if (in_byte == CH_DOT && !infrac_r) begin
                    infrac_nxt = 1'b1;
                  end else if (is_digit) begin
                    if (!infrac_r) begin
                      if (t36[35:32] != 4'd0) begin
                        int_nxt = 32'hFFFF_FFFF;
                        q_nxt   = 26'd42949672;
                        rem_nxt = 7'd95;
                      end else begin
                        int_nxt = t36[31:0];
                        q_nxt   = 26'(q_r * 26'd10 + 26'(hi));
                        rem_nxt = 7'(v10 - 10'(hi) * 10'd100);
                      end
                    end else if (fd_r < FRAC_MAX) begin
                      fd_nxt = fd_r + 3'd1;
                      if (fd_r < 3'd1) f1_nxt = d;
                      if (fd_r < 3'd2)
                        f2_nxt = f2_r + 7'(28'(d) * 28'(pow10(1 - int'(fd_r))));
                      if (fd_r < 3'd3)
                        f3_nxt = f3_r + 10'(28'(d) * 28'(pow10(2 - int'(fd_r))));
                      if (fd_r < 3'(MINUTE_FRAC_DIGITS))
                        fm_nxt = fm_r + 24'(28'(d) *
                                 28'(pow10(int'(MINUTE_FRAC_DIGITS) - 1 - int'(fd_r))));
                    end
                  end
                end
              end
            end
          end
          PH_HEX1: begin
            chk_nxt   = hexv;
            phase_nxt = PH_HEX2;
          end
          PH_HEX2: begin
            phase_nxt = PH_IDLE;
            if (({chk_r[3:0], 4'h0} + hexv) == xor_r) evt_nxt.op = OP_COMMIT;
          end
          PH_IDLE: begin
          end
        endcase
      end
    end

    if (do_clear) begin
      int_nxt = '0;  q_nxt = '0;  rem_nxt = '0;
      f1_nxt = '0;   f2_nxt = '0; f3_nxt = '0; fm_nxt = '0; fd_nxt = '0;
      neg_nxt = 1'b0; infrac_nxt = 1'b0; started_nxt = 1'b0; first_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;  count_r <= '0;  xor_r <= '0;  chk_r <= '0;
      kind_r <= KIND_UNKNOWN;  addr3_r <= '0;  addr4_r <= '0;  field_r <= '0;
      int_r <= '0;  q_r <= '0;  rem_r <= '0;  f1_r <= '0;  f2_r <= '0;
      f3_r <= '0;  fm_r <= '0;  fd_r <= '0;  neg_r <= 1'b0;  infrac_r <= 1'b0;
      started_r <= 1'b0;  first_r <= '0;
      evt_r <= '0;
    end else begin
      if (adv) evt_r <= evt_nxt;
      if (accept) begin
        phase_r <= phase_nxt;  count_r <= count_nxt;  xor_r <= xor_nxt;
        chk_r <= chk_nxt;  kind_r <= kind_nxt;  addr3_r <= addr3_nxt;
        addr4_r <= addr4_nxt;  field_r <= field_nxt;  int_r <= int_nxt;
        q_r <= q_nxt;  rem_r <= rem_nxt;  f1_r <= f1_nxt;  f2_r <= f2_nxt;
        f3_r <= f3_nxt;  fm_r <= fm_nxt;  fd_r <= fd_nxt;  neg_r <= neg_nxt;
        infrac_r <= infrac_nxt;  started_r <= started_nxt;  first_r <= first_nxt;
      end
    end
  end

  assign evt_o = evt_r;

endmodule

[design/nmea_conv.sv]
// Three-stage pipeline that turns a finished field into scaled, saturated values.
// Depends on nmea_pkg; fed by nmea_front, feeds nmea_commit.
module nmea_conv import nmea_pkg::*; #(
  parameter int unsigned MINUTE_FRAC_DIGITS = MINUTE_FRAC_DIGITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     adv,
  input  fld_evt_t evt_i,
  output shd_evt_t evt_o
);

  localparam logic [30:0] FM_SCALE = 31'(pow10(7 - int'(MINUTE_FRAC_DIGITS)));

  typedef struct packed {
    evt_op_t     op;
    kind_t       kind;
    logic [4:0]  field;
    logic        neg, hem_s, hem_w;
    logic [7:0]  small_v;
    logic [38:0] pdop_raw;
    logic [35:0] alt_raw;
    logic [41:0] spd_raw;
    logic [49:0] deg_prod;
    logic [27:0] y;
  } s1_t;

  typedef struct packed {
    evt_op_t            op;
    kind_t              kind;
    logic [4:0]         field;
    logic               neg, hem_s, hem_w;
    logic [7:0]         small_v;
    logic [15:0]        pdop_v;
    logic signed [20:0] alt_v;
    logic [23:0]        spd_v;
    logic [49:0]        deg_prod;
    logic [24:0]        quo;
  } s2_t;

  s1_t      s1_r, s1_nxt;
  s2_t      s2_r, s2_nxt;
  shd_evt_t s3_r, s3_nxt;

  logic [30:0] x31;
  logic [59:0] quo_full;
  logic [20:0] alt_mag;
  logic [50:0] mag51;
  logic [31:0] cmag;

  // Stage 1: fixed-point scaling of the accumulators.
  always_comb begin
    s1_nxt.op    = evt_i.op;
    s1_nxt.kind  = evt_i.kind;
    s1_nxt.field = evt_i.field;
    s1_nxt.neg   = evt_i.neg;
    s1_nxt.hem_s = evt_i.hem_s;
    s1_nxt.hem_w = evt_i.hem_w;
    s1_nxt.small_v  = (evt_i.int_val > 32'd255) ? 8'd255 : evt_i.int_val[7:0];
    s1_nxt.pdop_raw = 39'(evt_i.int_val) * 39'd100 + 39'(evt_i.f2);
    s1_nxt.alt_raw  = 36'(evt_i.int_val) * 36'd10 + 36'(evt_i.f1);
    s1_nxt.spd_raw  = 42'(evt_i.int_val) * 42'd1000 + 42'(evt_i.f3);
    s1_nxt.deg_prod = 50'(evt_i.deg) * 50'd10000000;
    // Minutes scaled to 1e7, still to be divided by 60.
    x31      = 31'(evt_i.rem) * 31'd10000000 + 31'(evt_i.fm) * FM_SCALE;
    s1_nxt.y = 28'(x31 >> 2);
  end

  // Stage 2: saturation and division of the minutes by 15 (after the shift by 2).
  always_comb begin
    s2_nxt.op       = s1_r.op;
    s2_nxt.kind     = s1_r.kind;
    s2_nxt.field    = s1_r.field;
    s2_nxt.neg      = s1_r.neg;
    s2_nxt.hem_s    = s1_r.hem_s;
    s2_nxt.hem_w    = s1_r.hem_w;
    s2_nxt.small_v  = s1_r.small_v;
    s2_nxt.deg_prod = s1_r.deg_prod;
    quo_full        = 60'(s1_r.y) * 60'h0_8888_8889;
    s2_nxt.quo      = quo_full[59:35];
    if (s1_r.neg) s2_nxt.pdop_v = '0;
    else if (s1_r.pdop_raw > 39'd65535) s2_nxt.pdop_v = 16'hFFFF;
    else s2_nxt.pdop_v = s1_r.pdop_raw[15:0];
    if (s1_r.neg) s2_nxt.spd_v = '0;
    else if (s1_r.spd_raw > 42'd16777215) s2_nxt.spd_v = 24'hFF_FFFF;
    else s2_nxt.spd_v = s1_r.spd_raw[23:0];
    alt_mag = (s1_r.alt_raw > 36'd1000000) ? 21'd1000000 : s1_r.alt_raw[20:0];
    s2_nxt.alt_v = s1_r.neg ? -$signed(alt_mag) : $signed(alt_mag);
  end

  // Stage 3: coordinate magnitude, saturation and sign.
  always_comb begin
    s3_nxt.op      = s2_r.op;
    s3_nxt.kind    = s2_r.kind;
    s3_nxt.field   = s2_r.field;
    s3_nxt.hem_s   = s2_r.hem_s;
    s3_nxt.hem_w   = s2_r.hem_w;
    s3_nxt.small_v = s2_r.small_v;
    s3_nxt.pdop_v  = s2_r.pdop_v;
    s3_nxt.alt_v   = s2_r.alt_v;
    s3_nxt.spd_v   = s2_r.spd_v;
    mag51 = 51'(s2_r.deg_prod) + 51'(s2_r.quo);
    cmag  = (mag51 > 51'd1800000000) ? 32'd1800000000 : mag51[31:0];
    s3_nxt.coord_v = s2_r.neg ? -$signed(cmag) : $signed(cmag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
      s3_r <= '0;
    end else if (adv) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
    end
  end

  assign evt_o = s3_r;

endmodule

[design/nmea_commit.sv]
// Shadow value set, committed navigation state and the result register.
// Depends on nmea_pkg; fed by nmea_conv.
module nmea_commit import nmea_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     adv,
  input  shd_evt_t evt_i,
  output logic     out_valid_o,
  output res_t     out_res_o
);

  logic signed [31:0] sh_r [4];
  logic signed [31:0] sh_nxt [4];
  logic [7:0]         mode_r, mode_nxt;
  logic [15:0]        pdop_r, pdop_nxt;
  logic signed [31:0] lat_r, lat_nxt, lon_r, lon_nxt;
  logic [7:0]         sats_r, sats_nxt;
  logic signed [20:0] alt_r, alt_nxt;
  logic [23:0]        spd_r, spd_nxt;
  logic               emit, valid_r;
  res_t               res_r, res_nxt;

  always_comb begin
    for (int i = 0; i < 4; i++) sh_nxt[i] = sh_r[i];
    mode_nxt = mode_r;  pdop_nxt = pdop_r;  lat_nxt = lat_r;  lon_nxt = lon_r;
    sats_nxt = sats_r;  alt_nxt = alt_r;    spd_nxt = spd_r;
    emit = 1'b0;

    unique case (evt_i.op)
      OP_NONE: begin
      end
      OP_CLEAR: begin
        for (int i = 0; i < 4; i++) sh_nxt[i] = '0;
      end
      OP_FINISH: begin
        unique case (evt_i.kind)
          KIND_GSA: begin
            if (evt_i.field == 5'd1)  sh_nxt[0] = 32'(evt_i.small_v);
            if (evt_i.field == 5'd14) sh_nxt[1] = 32'(evt_i.pdop_v);
          end
          KIND_GNS: begin
            if (evt_i.field == 5'd1) sh_nxt[0] = evt_i.coord_v;
            if (evt_i.field == 5'd2 && evt_i.hem_s) sh_nxt[0] = -sh_r[0];
            if (evt_i.field == 5'd3) sh_nxt[1] = evt_i.coord_v;
            if (evt_i.field == 5'd4 && evt_i.hem_w) sh_nxt[1] = -sh_r[1];
            if (evt_i.field == 5'd6) sh_nxt[2] = 32'(evt_i.small_v);
            if (evt_i.field == 5'd8) sh_nxt[3] = 32'(evt_i.alt_v);
          end
          KIND_VTG: begin
            if (evt_i.field == 5'd6) sh_nxt[0] = 32'(evt_i.spd_v);
          end
          KIND_UNKNOWN: begin
          end
        endcase
      end
      OP_COMMIT: begin
        if (evt_i.kind == KIND_GSA) begin
          mode_nxt = sh_r[0][7:0];
          pdop_nxt = sh_r[1][15:0];
          emit = 1'b1;
        end else if (evt_i.kind == KIND_GNS && mode_r == NAV_MODE_3D) begin
          lat_nxt  = sh_r[0];
          lon_nxt  = sh_r[1];
          sats_nxt = sh_r[2][7:0];
          alt_nxt  = sh_r[3][20:0];
          emit = 1'b1;
        end else if (evt_i.kind == KIND_VTG && mode_r == NAV_MODE_3D) begin
          spd_nxt = sh_r[0][23:0];
          emit = 1'b1;
        end
      end
    endcase

    res_nxt.kind = evt_i.kind;
    res_nxt.mode = mode_nxt;
    res_nxt.pdop = pdop_nxt;
    res_nxt.lat  = lat_nxt;
    res_nxt.lon  = lon_nxt;
    res_nxt.sats = sats_nxt;
    res_nxt.alt  = alt_nxt;
    res_nxt.spd  = spd_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) sh_r[i] <= '0;
      mode_r <= NAV_MODE_RESET;  pdop_r <= PDOP_RESET;
      lat_r <= '0;  lon_r <= '0;  sats_r <= '0;  alt_r <= '0;  spd_r <= '0;
      valid_r <= 1'b0;
      res_r <= '0;
    end else if (adv) begin
      for (int i = 0; i < 4; i++) sh_r[i] <= sh_nxt[i];
      mode_r <= mode_nxt;  pdop_r <= pdop_nxt;
      lat_r <= lat_nxt;  lon_r <= lon_nxt;  sats_r <= sats_nxt;
      alt_r <= alt_nxt;  spd_r <= spd_nxt;
      valid_r <= emit;
      res_r <= res_nxt;
    end
  end

  assign out_valid_o = valid_r;
  assign out_res_o   = res_r;

endmodule

[test/tb_top.sv]
// Self-checking testbench for nmea_sentence_parser: builds NMEA sentences,
// predicts every committed navigation beat and checks the result stream.
// Depends on nmea_pkg and the nmea_sentence_parser RTL.
module tb_top;
  import nmea_pkg::*;

  localparam int HOLD_MARK = 256;  // queue entry: pause until all results are out
  localparam int BODY_LIMIT = BUFFER_SIZE_DEF - 1;
  localparam int MIN_DIGITS = MINUTE_FRAC_DIGITS_DEF;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_BODY = 2'd1;
  localparam logic [1:0] PH_HEX1 = 2'd2;
  localparam logic [1:0] PH_HEX2 = 2'd3;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = 8'h00;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [143:0] out_tdata;
  logic [1:0]   out_tuser;

  nmea_sentence_parser dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always #5 clk = ~clk;

  int   char_queue[$];   // characters still to send, plus hold marks
  res_t nav_expect[$];   // committed navigation beats still owed by the block
  int   fail_count = 0;

  // ---------------------------------------------------------------------
  // Sentence predictor state.
  // ---------------------------------------------------------------------
  logic [1:0]  p_phase;
  int          p_count;
  logic [7:0]  p_xor, p_hi;
  kind_t       p_kind;
  int          p_field;
  logic [31:0] p_int, p_frac;
  int          p_fdig;
  bit          p_neg, p_infrac, p_started;
  logic [7:0]  p_first, p_a3, p_a4;
  longint      p_shadow[4];
  logic [7:0]  c_mode;
  logic [15:0] c_pdop;
  logic [31:0] c_lat, c_lon;
  longint      c_sats, c_alt, c_spd;

  function automatic longint unsigned ten_pow(input int k);
    longint unsigned p = 1;
    repeat (k) p = p * 10;
    return p;
  endfunction

  // Fraction rescaled to exactly n digits, truncating extra ones.
  function automatic longint unsigned frac_at(input int n);
    if (p_fdig >= n) return p_frac / ten_pow(p_fdig - n);
    return longint'(p_frac) * ten_pow(n - p_fdig);
  endfunction

  function automatic longint sat_signed(input longint unsigned mag, input longint lim);
    longint v = (mag > lim) ? lim : longint'(mag);
    return p_neg ? -v : v;
  endfunction

  function automatic longint sat_unsigned(input longint unsigned mag, input longint lim);
    if (p_neg) return 0;
    return (mag > lim) ? lim : longint'(mag);
  endfunction

  function automatic longint count_val();
    return (p_int > 255) ? 255 : longint'(p_int);
  endfunction

  // ddmm.mmmm to degrees times 1e7.
  function automatic longint coord_val();
    longint unsigned scale = ten_pow(MIN_DIGITS);
    longint unsigned mins = longint'(p_int % 100) * scale + frac_at(MIN_DIGITS);
    longint unsigned mag = longint'(p_int / 100) * 10000000 + mins * 10000000 / (60 * scale);
    return sat_signed(mag, 1800000000);
  endfunction

  function automatic void clear_number();
    p_int = 0; p_frac = 0; p_fdig = 0;
    p_neg = 0; p_infrac = 0; p_started = 0; p_first = 0;
  endfunction

  function automatic void close_field();
    case (p_kind)
      KIND_GSA: begin
        if (p_field == 1) p_shadow[0] = count_val();
        if (p_field == 14)
          p_shadow[1] = sat_unsigned(longint'(p_int) * 100 + frac_at(2), 65535);
      end
      KIND_GNS: begin
        if (p_field == 1) p_shadow[0] = coord_val();
        if (p_field == 2 && p_first == CH_SOUTH) p_shadow[0] = -p_shadow[0];
        if (p_field == 3) p_shadow[1] = coord_val();
        if (p_field == 4 && p_first == CH_WEST) p_shadow[1] = -p_shadow[1];
        if (p_field == 6) p_shadow[2] = count_val();
        if (p_field == 8)
          p_shadow[3] = sat_signed(longint'(p_int) * 10 + frac_at(1), 1000000);
      end
      KIND_VTG: begin
        if (p_field == 6)
          p_shadow[0] = sat_unsigned(longint'(p_int) * 1000 + frac_at(3), 16777215);
      end
      default: ;
    endcase
    if (p_field < 31) p_field++;
    clear_number();
  endfunction

  function automatic void number_char(input logic [7:0] b);
    longint unsigned t;
    if (!p_started) begin
      p_first = b;
      p_started = 1;
      if (b == CH_MINUS) begin
        p_neg = 1;
        return;
      end
    end
    if (b == CH_DOT && !p_infrac) begin
      p_infrac = 1;
    end else if (b >= CH_ZERO && b <= CH_NINE) begin
      if (!p_infrac) begin
        t = longint'(p_int) * 10 + (b - CH_ZERO);
        p_int = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
      end else if (p_fdig < 7) begin
        p_frac = p_frac * 10 + (b - CH_ZERO);
        p_fdig++;
      end
    end
  endfunction

  function automatic logic [7:0] hex_digit(input logic [7:0] b);
    return (b < 58) ? b - 8'd48 : b - 8'd55;
  endfunction

  function automatic void begin_sentence();
    p_phase = PH_BODY; p_count = 0; p_xor = 0; p_kind = KIND_UNKNOWN;
    p_field = 0; p_a3 = 0; p_a4 = 0;
    for (int i = 0; i < 4; i++) p_shadow[i] = 0;
    clear_number();
  endfunction

  function automatic void predictor_reset();
    begin_sentence();
    p_phase = PH_IDLE; p_hi = 0;
    c_mode = NAV_MODE_RESET; c_pdop = PDOP_RESET;
    c_lat = 0; c_lon = 0; c_sats = 0; c_alt = 0; c_spd = 0;
  endfunction

  // Advances the predictor by one character; queues a beat on a commit.
  function automatic void predict_char(input logic [7:0] b);
    res_t r;
    if (b == CH_DOLLAR) begin
      begin_sentence();
      return;
    end
    if (b == CH_STAR) begin
      if (p_phase == PH_BODY) begin
        if (p_count >= 7) close_field();
        p_phase = PH_HEX1;
      end
      return;
    end
    case (p_phase)
      PH_BODY: begin
        if (p_count >= BODY_LIMIT) begin
          p_phase = PH_IDLE;
          return;
        end
        p_xor ^= b;
        p_count++;
        if (p_count == 3) p_a3 = b;
        else if (p_count == 4) p_a4 = b;
        else if (p_count == 5) begin
          if (p_a3 == "G" && p_a4 == "S" && b == "A") p_kind = KIND_GSA;
          else if (p_a3 == "G" && p_a4 == "N" && b == "S") p_kind = KIND_GNS;
          else if (p_a3 == "V" && p_a4 == "T" && b == "G") p_kind = KIND_VTG;
          else p_kind = KIND_UNKNOWN;
        end else if (p_count >= 7) begin
          if (b == CH_COMMA) close_field();
          else number_char(b);
        end
      end
      PH_HEX1: begin
        p_hi = hex_digit(b);
        p_phase = PH_HEX2;
      end
      PH_HEX2: begin
        p_phase = PH_IDLE;
        if (8'(p_hi * 16 + hex_digit(b)) != p_xor) return;
        if (p_kind == KIND_GSA) begin
          c_mode = p_shadow[0][7:0];
          c_pdop = p_shadow[1][15:0];
        end else if (p_kind == KIND_GNS && c_mode == NAV_MODE_3D) begin
          c_lat = p_shadow[0][31:0];
          c_lon = p_shadow[1][31:0];
          c_sats = p_shadow[2];
          c_alt = p_shadow[3];
        end else if (p_kind == KIND_VTG && c_mode == NAV_MODE_3D) begin
          c_spd = p_shadow[0];
        end else begin
          return;
        end
        r.kind = p_kind; r.mode = c_mode; r.pdop = c_pdop;
        r.lat = c_lat; r.lon = c_lon; r.sats = c_sats[7:0];
        r.alt = c_alt[20:0]; r.spd = c_spd[23:0];
        nav_expect.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus builders.
  // ---------------------------------------------------------------------
  // Queues "$", the body, "*" and the checksum; corrupt flips checksum bits.
  task automatic send_sentence(input string body, input bit corrupt, input bit lower_hex);
    logic [7:0] sum = 0;
    string hexset;
    hexset = lower_hex ? "0123456789abcdef" : "0123456789ABCDEF";
    for (int i = 0; i < body.len(); i++) sum ^= body[i];
    if (corrupt) sum ^= 8'($urandom_range(1, 255));
    char_queue.push_back(CH_DOLLAR);
    for (int i = 0; i < body.len(); i++) char_queue.push_back(body[i]);
    char_queue.push_back(CH_STAR);
    char_queue.push_back(hexset[sum[7:4]]);
    char_queue.push_back(hexset[sum[3:0]]);
  endtask

  function automatic string join_fields(input string head, input string f[$]);
    string s = {head, ","};
    foreach (f[i]) s = (i == 0) ? {s, f[i]} : {s, ",", f[i]};
    return s;
  endfunction

  function automatic string digits(input int n);
    string s = "";
    repeat (n) s = {s, string'(8'($urandom_range(48, 57)))};
    return s;
  endfunction

  // A random number text: sign, integer part, fraction, sometimes junk.
  function automatic string rand_number(input int max_int);
    string s = "";
    int n_int, n_frac;
    n_int = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 12) : $urandom_range(1, max_int);
    if ($urandom_range(0, 9) == 0) s = "-";
    s = {s, digits(n_int)};
    if ($urandom_range(0, 3) != 0) begin
      n_frac = $urandom_range(0, 9);
      s = {s, ".", digits(n_frac)};
    end
    if ($urandom_range(0, 11) == 0) s = {s, string'(8'($urandom_range(33, 126)))};
    if (s.len() > 0 && (s[s.len()-1] == CH_DOLLAR || s[s.len()-1] == CH_STAR ||
                        s[s.len()-1] == CH_COMMA))
      s = s.substr(0, s.len() - 2);
    return s;
  endfunction

  function automatic string make_gsa(input string mode_txt, input string pdop_txt);
    string f[$];
    f.push_back("A"); f.push_back(mode_txt);
    repeat (12) f.push_back($urandom_range(0, 1) ? digits(2) : "");
    f.push_back(pdop_txt); f.push_back("1.2"); f.push_back("0.9");
    return join_fields("GPGSA", f);
  endfunction

  function automatic string make_gns(input string lat, input string ns, input string lon,
                                     input string ew, input string sats, input string alt);
    string f[$];
    f.push_back("123519.00"); f.push_back(lat); f.push_back(ns); f.push_back(lon);
    f.push_back(ew); f.push_back("AAN"); f.push_back(sats); f.push_back("0.9");
    f.push_back(alt); f.push_back("46.9");
    return join_fields("GNGNS", f);
  endfunction

  function automatic string make_vtg(input string kph);
    string f[$];
    f.push_back("54.7"); f.push_back("T"); f.push_back("34.4"); f.push_back("M");
    f.push_back("5.5"); f.push_back("N"); f.push_back(kph); f.push_back("K");
    return join_fields("GPVTG", f);
  endfunction

  function automatic string rand_hem(input string neg_letter, input string pos_letter);
    case ($urandom_range(0, 3))
      0: return neg_letter;
      1: return "";
      2: return string'(8'($urandom_range(65, 90)));
      default: return pos_letter;
    endcase
  endfunction

  task automatic random_sentence();
    int pick = $urandom_range(0, 99);
    bit bad = ($urandom_range(0, 9) == 0);
    bit low = ($urandom_range(0, 15) == 0);
    string body;
    if (pick < 15)
      body = make_gsa(($urandom_range(0, 4) != 0) ? "3" : rand_number(3), rand_number(4));
    else if (pick < 55)
      body = make_gns(rand_number(5), rand_hem("S", "N"), rand_number(6),
                      rand_hem("W", "E"), rand_number(2), rand_number(6));
    else if (pick < 85)
      body = make_vtg(rand_number(6));
    else if (pick < 90)
      body = join_fields($sformatf("%s%s", digits(2), "XYZ"), '{rand_number(3)});
    else begin
      // Truncated sentence or raw line noise between sentences.
      repeat ($urandom_range(1, 20)) char_queue.push_back($urandom_range(0, 255));
      return;
    end
    send_sentence(body, bad, low);
  endtask

  // ---------------------------------------------------------------------
  // Driver: bursts of beats separated by random gaps.
  // ---------------------------------------------------------------------
  bit in_took = 0;
  int burst_left = 0, gap_left = 0;

  always @(negedge clk) begin
    logic nxt_valid;
    nxt_valid = in_tvalid;
    if (rst_n && !(in_tvalid && !in_took)) begin
      nxt_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (char_queue.size() > 0) begin
        if (char_queue[0] == HOLD_MARK) begin
          if (nav_expect.size() == 0) void'(char_queue.pop_front());
        end else begin
          nxt_valid = 1'b1;
          in_tdata <= char_queue[0][7:0];
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(0, 20);
            gap_left = $urandom_range(0, 6);
          end
        end
      end
    end
    in_tvalid <= nxt_valid;
  end

  // ---------------------------------------------------------------------
  // Receiver: alternates full-rate and stall patterns, with one long hold.
  // ---------------------------------------------------------------------
  int rx_cycle = 0;
  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle >= 3000 && rx_cycle < 3400)
      out_tready <= 1'b0;
    else if ((rx_cycle / 300) % 2 == 0)
      out_tready <= 1'b1;
    else
      out_tready <= ((rx_cycle * 13) % 11) < 6;
  end

  // ---------------------------------------------------------------------
  // Monitor: feeds accepted characters to the predictor, checks results.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    res_t want;
    in_took = 0;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        in_took = 1;
        predict_char(in_tdata);
        void'(char_queue.pop_front());
      end
      if (out_tvalid && out_tready) begin
        if (nav_expect.size() == 0) begin
          $error("result beat with no sentence committed");
          fail_count++;
        end else begin
          want = nav_expect.pop_front();
          if (out_tuser != want.kind) begin
            $error("sentence_kind exp %0d got %0d", want.kind, out_tuser); fail_count++;
          end
          if (out_tdata[7:0] != want.mode) begin
            $error("nav_mode exp %0d got %0d", want.mode, out_tdata[7:0]); fail_count++;
          end
          if (out_tdata[23:8] != want.pdop) begin
            $error("pdop_centi exp %0d got %0d", want.pdop, out_tdata[23:8]); fail_count++;
          end
          if (out_tdata[55:24] != want.lat) begin
            $error("lat_deg_e7 exp %0d got %0d", want.lat, $signed(out_tdata[55:24]));
            fail_count++;
          end
          if (out_tdata[87:56] != want.lon) begin
            $error("lon_deg_e7 exp %0d got %0d", want.lon, $signed(out_tdata[87:56]));
            fail_count++;
          end
          if (out_tdata[95:88] != want.sats) begin
            $error("num_sats exp %0d got %0d", want.sats, out_tdata[95:88]); fail_count++;
          end
          if (out_tdata[116:96] != want.alt) begin
            $error("alt_decim exp %0d got %0d", want.alt, $signed(out_tdata[116:96]));
            fail_count++;
          end
          if (out_tdata[140:117] != want.spd) begin
            $error("speed_kph_milli exp %0d got %0d", want.spd, out_tdata[140:117]);
            fail_count++;
          end
          if (out_tdata[143:141] != 3'b000) begin
            $error("pad bits exp 0 got %0h", out_tdata[143:141]); fail_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------
  initial begin
    string longbody;
    predictor_reset();
    // Directed part: rejected kinds first, while the reset mode is not 3.
    send_sentence(make_gns("4807.038", "N", "01131.000", "E", "08", "545.4"), 0, 0);
    send_sentence(make_vtg("10.2"), 0, 0);
    char_queue.push_back(CH_STAR);  // star outside a sentence
    send_sentence(make_gsa("3", "1.94"), 0, 0);
    send_sentence(make_gsa("3", "2.5"), 1, 0);  // checksum mismatch
    send_sentence(make_gns("9999999999999.9999999", "S", "18000.00000", "W", "999",
                           "-99999999.9"), 0, 0);
    send_sentence(make_gns("-0000.000001", "N", "-4807.5", "E", "", "100000.05"), 0, 0);
    send_sentence(make_vtg("99999999"), 0, 0);
    send_sentence(make_vtg("-5.0"), 0, 0);
    send_sentence(make_vtg("1.23456789"), 0, 1);
    send_sentence("GPGN", 0, 0);                 // ends before the fields begin
    send_sentence("GPXYZ,1,2,3", 0, 0);          // unknown type
    send_sentence(make_gsa("2", "-3"), 0, 0);    // leaves 3D fix
    send_sentence(make_vtg("7"), 0, 0);          // rejected now
    send_sentence(make_gsa("3", "655.36"), 0, 0);
    longbody = "GPVTG,";
    repeat (BODY_LIMIT) longbody = {longbody, "1"};
    send_sentence(longbody, 0, 0);               // overlong, dropped
    char_queue.push_back(8'h00);
    char_queue.push_back(8'hFF);
    char_queue.push_back(CH_DOLLAR);
    char_queue.push_back(8'hA5);
    char_queue.push_back(8'h5A);
    send_sentence(make_vtg("12.5"), 0, 0);
    char_queue.push_back(HOLD_MARK);
    // Random part.
    for (int i = 0; i < 90; i++) begin
      random_sentence();
      if (i == 45) char_queue.push_back(HOLD_MARK);
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 5)) char_queue.push_back($urandom_range(0, 255));
    end
    send_sentence(make_gsa("3", "1.0"), 0, 0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    wait (char_queue.size() == 0 && nav_expect.size() == 0);
    repeat (30) @(posedge clk);
    if (fail_count == 0 && nav_expect.size() == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    #3000000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

[sim.f]
design/nmea_pkg.sv
design/nmea_front.sv
design/nmea_conv.sv
design/nmea_commit.sv
design/nmea_sentence_parser.sv
test/tb_top.sv
